@@ sv/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define DWS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent leads to a consequent in the next cycle.
`define DWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dws_pkg.sv @@
// Shared action codes, status codes and cell control type for the deque.
`timescale 1ns / 1ps
package dws_pkg;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SEARCH     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic shift_back;
    logic shift_front;
    logic load_back;
  } cell_ctl_t;

endpackage

@@ sv/dws_cell.sv @@
// One storage cell of the deque chain: holds the entry at one position from the front.
`timescale 1ns / 1ps
module dws_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic              clk,
  input  dws_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     count,
  input  logic [31:0]       value,
  input  logic [31:0]       prev_data,
  input  logic [31:0]       next_data,
  output logic [31:0]       data,
  output logic              hit,
  output logic [31:0]       tail_data
);
  import dws_pkg::*;

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_C1 = CW'(IDX + 1);

  logic [31:0] data_r;
  logic [31:0] data_nxt;
  logic        occupied;

  assign occupied  = IDX_C < count;
  assign hit       = occupied && (data_r == value);
  assign tail_data = (IDX_C1 == count) ? data_r : 32'd0;
  assign data      = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_back) begin
      data_nxt = prev_data;
    end else if (ctl.shift_front) begin
      data_nxt = next_data;
    end else if (ctl.load_back && (IDX_C == count)) begin
      data_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ sv/deque_with_search.sv @@
// Top level of the bounded double-ended queue with membership search.
// Usage:
//   Input channel in_valid/in_ready carries in_action and in_value. Actions:
//   push front, push back, pop front, pop back, search; other codes do nothing.
//   Result channel out_valid/out_ready carries out_popped_value, out_found
//   and out_status (ok, push refused because full, pop refused because empty).
//   Every accepted item yields exactly one result, registered: it appears in the
//   cycle after the transfer on the input side.
//   Throughput is one item per cycle while no waiting result is held back by
//   out_ready. Entries live in a chain of DEPTH cells ordered from the front;
//   a push or pop at the front moves every cell by one position at once, a
//   back access uses the entry count, and a search compares all occupied cells at once.
//   While a result waits for out_ready, in_ready follows out_ready, so the
//   next item is taken in the same cycle the waiting result leaves.
//   Reset empties the queue and drops any pending result; entry contents are
//   not cleared and are never read before being written.
`timescale 1ns / 1ps
module deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_popped_value,
  output logic               out_found,
  output logic [1:0]         out_status
);
  import dws_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic [31:0]   popped_r;
  logic [31:0]   popped_nxt;
  logic          found_r;
  logic          found_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;

  logic          xfer;
  logic          full;
  logic          empty;
  cell_ctl_t     ctl;

  logic [31:0]      data_w [DEPTH];
  logic [31:0]      tail_w [DEPTH];
  logic [DEPTH-1:0] hit_w;
  logic [31:0]      tail_or;

  assign in_ready = !out_valid_r || out_ready;
  assign xfer     = in_valid && in_ready;
  assign full     = count_r == FULL_C;
  assign empty    = count_r == '0;

  always_comb begin
    ctl.shift_back  = xfer && (in_action == ACT_PUSH_FRONT) && !full;
    ctl.shift_front = xfer && (in_action == ACT_POP_FRONT) && !empty;
    ctl.load_back   = xfer && (in_action == ACT_PUSH_BACK) && !full;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [31:0] prev_d;
      logic [31:0] next_d;
      if (g == 0) begin : g_first
        assign prev_d = in_value;
      end else begin : g_mid
        assign prev_d = data_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign next_d = data_w[g];
      end else begin : g_inner
        assign next_d = data_w[g+1];
      end
      dws_cell #(
        .IDX (g),
        .CW  (CW)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .value     (in_value),
        .prev_data (prev_d),
        .next_data (next_d),
        .data      (data_w[g]),
        .hit       (hit_w[g]),
        .tail_data (tail_w[g])
      );
    end
  endgenerate

  always_comb begin
    tail_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_or = tail_or | tail_w[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    found_nxt  = 1'b0;
    status_nxt = ST_OK;
    case (in_action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = data_w[0];
          count_nxt  = count_r - CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = tail_or;
          count_nxt  = count_r - CW'(1);
        end
      end
      ACT_SEARCH: begin
        found_nxt = |hit_w;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      popped_r <= popped_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_found        = found_r;
  assign out_status       = status_r;

endmodule

@@ sv/dws_checker.sv @@
// Port-level checker for the deque, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_popped_value,
  input logic               out_found,
  input logic [1:0]         out_status
);
  import dws_pkg::*;

  `DWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_popped_value) && $stable(out_status), "stalled result changed")
  `DWS_ASSERT_NEXT(a_one_result, in_valid && in_ready, out_valid, "transfer produced no result")
  `DWS_ASSERT_ALWAYS(a_status_code, !out_valid || out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY, "invalid status code")
  `DWS_ASSERT_ALWAYS(a_refused_zero, !out_valid || out_status == ST_OK || (out_popped_value == 32'sd0 && !out_found), "refused action carries data")
  `DWS_ASSERT_ALWAYS(a_found_only, !out_valid || !out_found || out_popped_value == 32'sd0, "search result carries popped data")

endmodule

bind deque_with_search dws_checker u_dws_checker (.*);

@@ tb/deque_with_search_tb.sv @@
// Self-checking testbench for the deque with membership search: directed and random actions.
`timescale 1ns / 1ps
module deque_with_search_tb;
  import dws_pkg::*;

  localparam int DEPTH = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0] ACT_RSVD_LAST = 3'd7;

  typedef struct packed {
    logic signed [31:0] popped;
    logic               found;
    logic [1:0]         status;
  } deque_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_action = ACT_PUSH_FRONT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_popped_value;
  logic               out_found;
  logic [1:0]         out_status;

  logic signed [31:0] deque_model[$];
  deque_result_t      pending_results[$];

  int idle_pct = 37;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int item_count = 0;
  int pushes_done = 0;
  int pops_done = 0;
  int searches_done = 0;
  int search_hits = 0;
  int refused_pushes = 0;
  int refused_pops = 0;
  int reserved_seen = 0;

  deque_with_search #(.DEPTH(DEPTH)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_found        (out_found),
    .out_status       (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic predict_result(input logic [2:0] act, input logic signed [31:0] val);
    deque_result_t r;
    r = '0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (deque_model.size() >= DEPTH) begin
          r.status = ST_FULL;
          refused_pushes++;
        end else begin
          if (act == ACT_PUSH_FRONT) deque_model.push_front(val);
          else deque_model.push_back(val);
          pushes_done++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (deque_model.size() == 0) begin
          r.status = ST_EMPTY;
          refused_pops++;
        end else begin
          if (act == ACT_POP_FRONT) r.popped = deque_model.pop_front();
          else r.popped = deque_model.pop_back();
          pops_done++;
        end
      end
      ACT_SEARCH: begin
        foreach (deque_model[i]) begin
          if (deque_model[i] == val) r.found = 1'b1;
        end
        searches_done++;
        if (r.found) search_hits++;
      end
      default: begin
        reserved_seen++;
      end
    endcase
    r.status = r.status | ST_OK;
    pending_results.push_back(r);
    item_count++;
  endtask

  task automatic send_item(input logic [2:0] act, input logic signed [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_result(act, val);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [2:0] pick_action(input int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
    if (r < 18) return ACT_SEARCH;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && deque_model.size() > 0)
      return deque_model[$urandom_range(0, deque_model.size() - 1)];
    if (r < 55) return int'($urandom_range(0, 16)) - 8;
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic test_empty_store();
    send_item(ACT_POP_FRONT, 32'sd5);
    send_item(ACT_POP_BACK, -32'sd5);
    send_item(ACT_SEARCH, 32'sd0);
    send_item(ACT_SEARCH, 32'sh8000_0000);
    for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++) send_item(3'(a), $urandom);
  endtask

  task automatic test_extremes_and_single();
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_item(ACT_SEARCH, 32'sh8000_0000);
    send_item(ACT_SEARCH, 32'sh7fff_ffff);
    send_item(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_item(ACT_SEARCH, 32'sh7fff_ffff);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_PUSH_BACK, -32'sd1);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_PUSH_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_SEARCH, 32'sd0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, (i % 2) ? ~i : i);
    end
    send_item(ACT_PUSH_FRONT, 32'sd99);
    send_item(ACT_PUSH_BACK, 32'sd99);
    send_item(ACT_SEARCH, ~32'sd1);
    send_item(ACT_SEARCH, 32'sd99);
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
    end
    send_item(ACT_POP_BACK, 32'sd0);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 10; phase++) begin
      for (int n = 0; n < 50; n++) send_item(pick_action((phase % 2) ? 30 : 70), pick_value());
    end
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    for (int n = 0; n < 150; n++) send_item(pick_action(n < 75 ? 65 : 35), pick_value());
    idle_pct = 37;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_item(pick_action(60), pick_value());
    drain_results();
    for (int n = 0; n < 20; n++) send_item(pick_action(50), pick_value());
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  initial begin
    deque_result_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: popped_value %0d found %0d status %0d",
                 out_popped_value, out_found, out_status);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_popped_value !== exp_r.popped) begin
            $error("popped_value: expected %0d, actual %0d", exp_r.popped, out_popped_value);
            fail_count++;
          end
          if (out_found !== exp_r.found) begin
            $error("found: expected %0d, actual %0d", exp_r.found, out_found);
            fail_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_status);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $error("no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_extremes_and_single();
    test_full_store();
    drain_results();
    test_random_mix();
    test_no_idle();
    test_backpressure();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Ran %0d items: %0d pushes, %0d pops, %0d searches (%0d hits), %0d reserved codes",
             item_count, pushes_done, pops_done, searches_done, search_hits, reserved_seen);
    $display("Refused %0d pushes on a full store and %0d pops on an empty one; %0d mismatches",
             refused_pushes, refused_pops, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
